[hw/rtl/cct_warm_cold_white_mixer_core_defines.svh]
// Assertion macros shared by the tunable-white mixer RTL.
// Included by the files that carry concurrent assertions; needs nothing else.
`ifndef CCT_WARM_COLD_WHITE_MIXER_CORE_DEFINES_SVH
`define CCT_WARM_COLD_WHITE_MIXER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CWM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CWM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cwm_pkg.sv]
// Types, constants and codes of the tunable-white mixer.
// Used by every module of the block except cwm_pipe_div; depends on nothing.
`default_nettype none

package cwm_pkg;

    localparam int KELVIN_W = 16;
    localparam int BRI_W    = 7;
    localparam int LEVEL_W  = 8;
    localparam int MIRED_W  = 20;
    localparam int WEIGHT_W = 16;
    localparam int B255_W   = 15;

    // Mired scale and Q15 weight constants.
    localparam logic [MIRED_W-1:0]  MIRED_SCALE = 20'd1000000;
    localparam logic [WEIGHT_W-1:0] Q15_HALF    = 16'd32768;
    localparam logic [WEIGHT_W-1:0] Q15_SPAN    = 16'd32767;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 16'd65535;
    localparam logic [BRI_W-1:0]    BRI_MAX     = 7'd100;

    // Register reset values and the mireds that follow from them.
    localparam logic [KELVIN_W-1:0] RESET_WARM_K    = 16'd2700;
    localparam logic [KELVIN_W-1:0] RESET_NEUTRAL_K = 16'd4000;
    localparam logic [KELVIN_W-1:0] RESET_COLD_K    = 16'd6500;
    localparam logic [MIRED_W-1:0]  RESET_WARM_M    = MIRED_W'(1000000 / 2700);
    localparam logic [MIRED_W-1:0]  RESET_NEUTRAL_M = MIRED_W'(1000000 / 4000);
    localparam logic [MIRED_W-1:0]  RESET_COLD_M    = MIRED_W'(1000000 / 6500);

    // Register indexes on the configuration port.
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_WARM    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_NEUTRAL = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLD    = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [KELVIN_W-1:0] target_kelvin;
        logic [BRI_W-1:0]    brightness_percent;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] warm_level;
        logic [LEVEL_W-1:0] cold_level;
    } t_out_item;

    typedef enum logic [2:0] {
        KIND_OFF,
        KIND_WARM_ONLY,
        KIND_COLD_ONLY,
        KIND_BOTH_FULL,
        KIND_MIX
    } t_kind;

    typedef enum logic [0:0] {
        CFG_IDLE,
        CFG_DIV
    } t_cfg_state;

    // Normalized endpoints and their mireds.
    typedef struct packed {
        logic [KELVIN_W-1:0] warm_k;
        logic [KELVIN_W-1:0] neutral_k;
        logic [KELVIN_W-1:0] cold_k;
        logic [MIRED_W-1:0]  warm_m;
        logic [MIRED_W-1:0]  neutral_m;
        logic [MIRED_W-1:0]  cold_m;
    } t_endpoints;

    // One classified word held in the queue.
    typedef struct packed {
        t_kind               kind;
        logic [KELVIN_W-1:0] k;
        logic [LEVEL_W-1:0]  full;
        logic [LEVEL_W-1:0]  lead;
        logic [B255_W-1:0]   b255;
    } t_job;

    typedef struct packed {
        t_job job;
        logic hi;
        logic sat_w;
        logic sat_c;
    } t_mix_tag;

    typedef struct packed {
        t_job job;
        logic warm_strong;
    } t_lvl_tag;

endpackage

`default_nettype wire

[hw/rtl/cwm_cfg.sv]
// Configuration registers, endpoint normalization and a serial mired divider.
// Depends on cwm_pkg.
`default_nettype none

module cwm_cfg (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [3:0]                             paddr,
    input  wire logic [31:0]                            pwdata,
    output logic      [31:0]                            prdata,
    output logic                                        pready,
    output logic                                        o_busy,
    output cwm_pkg::t_endpoints                         o_ep
);

    localparam int BIT_W = $clog2(cwm_pkg::MIRED_W);

    logic [cwm_pkg::KELVIN_W-1:0] r_warm_raw, r_neutral_raw, r_cold_raw;
    logic [cwm_pkg::MIRED_W-1:0]  r_warm_m, r_neutral_m, r_cold_m;
    cwm_pkg::t_cfg_state          r_state, n_state;
    logic [cwm_pkg::REG_IDX_W-1:0] r_sel;
    logic [BIT_W-1:0]             r_bit;
    logic [cwm_pkg::KELVIN_W-1:0] r_rem;
    logic [cwm_pkg::MIRED_W-1:0]  r_quo;

    logic                          wr;
    logic [cwm_pkg::REG_IDX_W-1:0] idx;
    logic [cwm_pkg::KELVIN_W-1:0]  lo_k, hi_k, mid_k, divisor;
    logic [BIT_W-1:0]              bit_idx;
    logic [cwm_pkg::KELVIN_W:0]    trial;
    logic                          ge;
    logic [cwm_pkg::MIRED_W-1:0]   quo_next, mired;
    logic                          last_bit;

    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign pready = 1'b1;

    // Read back the raw values as written, low 16 bits only.
    always_comb begin
        unique case (idx)
            cwm_pkg::REG_WARM:    prdata = 32'(r_warm_raw);
            cwm_pkg::REG_NEUTRAL: prdata = 32'(r_neutral_raw);
            cwm_pkg::REG_COLD:    prdata = 32'(r_cold_raw);
            default:              prdata = '0;
        endcase
    end

    // Order warm and cold, then clamp neutral between them.
    always_comb begin
        lo_k  = (r_warm_raw > r_cold_raw) ? r_cold_raw : r_warm_raw;
        hi_k  = (r_warm_raw > r_cold_raw) ? r_warm_raw : r_cold_raw;
        mid_k = r_neutral_raw;
        if (mid_k < lo_k) mid_k = lo_k;
        if (mid_k > hi_k) mid_k = hi_k;
    end

    // Divisor of the endpoint being converted.
    always_comb begin
        unique case (r_sel)
            cwm_pkg::REG_WARM:    divisor = lo_k;
            cwm_pkg::REG_NEUTRAL: divisor = mid_k;
            default:              divisor = hi_k;
        endcase
    end

    // One restoring step per cycle, quotient bits most significant first.
    always_comb begin
        bit_idx  = BIT_W'(cwm_pkg::MIRED_W - 1) - r_bit;
        trial    = {r_rem, cwm_pkg::MIRED_SCALE[bit_idx]};
        ge       = trial >= {1'b0, divisor};
        quo_next = {r_quo[cwm_pkg::MIRED_W-2:0], ge};
        mired    = (divisor == '0) ? '0 : quo_next;
        last_bit = r_bit == BIT_W'(cwm_pkg::MIRED_W - 1);
    end

    // Next state of the conversion sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cwm_pkg::CFG_IDLE: if (wr) n_state = cwm_pkg::CFG_DIV;
            cwm_pkg::CFG_DIV: begin
                if (wr) n_state = cwm_pkg::CFG_DIV;
                else if (last_bit && r_sel == cwm_pkg::REG_COLD) n_state = cwm_pkg::CFG_IDLE;
            end
            default: n_state = cwm_pkg::CFG_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        unique case (r_state)
            cwm_pkg::CFG_DIV: o_busy = 1'b1;
            default:          o_busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= cwm_pkg::CFG_IDLE;
            r_warm_raw    <= cwm_pkg::RESET_WARM_K;
            r_neutral_raw <= cwm_pkg::RESET_NEUTRAL_K;
            r_cold_raw    <= cwm_pkg::RESET_COLD_K;
            r_warm_m      <= cwm_pkg::RESET_WARM_M;
            r_neutral_m   <= cwm_pkg::RESET_NEUTRAL_M;
            r_cold_m      <= cwm_pkg::RESET_COLD_M;
            r_sel         <= cwm_pkg::REG_WARM;
            r_bit         <= '0;
            r_rem         <= '0;
            r_quo         <= '0;
        end else begin
            r_state <= n_state;
            if (wr) begin
                unique case (idx)
                    cwm_pkg::REG_WARM:    r_warm_raw    <= pwdata[cwm_pkg::KELVIN_W-1:0];
                    cwm_pkg::REG_NEUTRAL: r_neutral_raw <= pwdata[cwm_pkg::KELVIN_W-1:0];
                    cwm_pkg::REG_COLD:    r_cold_raw    <= pwdata[cwm_pkg::KELVIN_W-1:0];
                    default: ;
                endcase
                r_sel <= cwm_pkg::REG_WARM;
                r_bit <= '0;
                r_rem <= '0;
                r_quo <= '0;
            end else if (r_state == cwm_pkg::CFG_DIV) begin
                if (last_bit) begin
                    unique case (r_sel)
                        cwm_pkg::REG_WARM:    r_warm_m    <= mired;
                        cwm_pkg::REG_NEUTRAL: r_neutral_m <= mired;
                        default:              r_cold_m    <= mired;
                    endcase
                    r_sel <= r_sel + cwm_pkg::REG_IDX_W'(1);
                    r_bit <= '0;
                    r_rem <= '0;
                    r_quo <= '0;
                end else begin
                    r_bit <= r_bit + BIT_W'(1);
                    r_rem <= ge ? cwm_pkg::KELVIN_W'(trial - {1'b0, divisor})
                                : cwm_pkg::KELVIN_W'(trial);
                    r_quo <= quo_next;
                end
            end
        end
    end

    assign o_ep = '{warm_k: lo_k, neutral_k: mid_k, cold_k: hi_k,
                    warm_m: r_warm_m, neutral_m: r_neutral_m, cold_m: r_cold_m};

endmodule

`default_nettype wire

[hw/rtl/cwm_front.sv]
// Front end: accepts light settings and classifies them into queue words.
// Depends on cwm_pkg.
`default_nettype none

module cwm_front (
    input  wire logic                i_in_valid,
    input  cwm_pkg::t_in_item        i_in_item,
    output logic                     o_in_ready,
    input  cwm_pkg::t_endpoints      i_ep,
    input  wire logic                i_busy,
    input  wire logic                i_full,
    output logic                     o_push,
    output cwm_pkg::t_job            o_job
);

    logic [cwm_pkg::BRI_W-1:0]    b;
    logic [cwm_pkg::KELVIN_W-1:0] k;
    logic [14:0]                  x_full;
    logic [28:0]                  p_full;
    logic [15:0]                  x_strong;
    logic [32:0]                  p_strong;
    cwm_pkg::t_kind               kind;

    assign o_in_ready = !i_full && !i_busy;
    assign o_push     = i_in_valid && o_in_ready;

    // Full level (b*255+50)/100 and the stronger mixed level (510b+1)/200,
    // both by reciprocal multiplication.
    always_comb begin
        k        = i_in_item.target_kelvin;
        b        = (i_in_item.brightness_percent > cwm_pkg::BRI_MAX)
                   ? cwm_pkg::BRI_MAX : i_in_item.brightness_percent;
        x_full   = 15'(b) * 15'd255 + 15'd50;
        p_full   = 29'(x_full) * 29'd5243;
        x_strong = 16'(b) * 16'd510 + 16'd1;
        p_strong = 33'(x_strong) * 33'd83887;
    end

    // Special cases first; the rest is mixed.
    always_comb begin
        if (b == '0)                 kind = cwm_pkg::KIND_OFF;
        else if (k <= i_ep.warm_k)   kind = cwm_pkg::KIND_WARM_ONLY;
        else if (k >= i_ep.cold_k)   kind = cwm_pkg::KIND_COLD_ONLY;
        else if (k == i_ep.neutral_k) kind = cwm_pkg::KIND_BOTH_FULL;
        else                         kind = cwm_pkg::KIND_MIX;
    end

    assign o_job = '{kind:   kind,
                     k:      k,
                     full:   cwm_pkg::LEVEL_W'(p_full >> 19),
                     lead:   cwm_pkg::LEVEL_W'(p_strong >> 24),
                     b255:   cwm_pkg::B255_W'(15'(b) * 15'd255)};

endmodule

`default_nettype wire

[hw/rtl/cwm_queue.sv]
// Short queue of classified words between the front and back ends.
// Depends on cwm_pkg and the assertion macro header.
`default_nettype none
`include "cct_warm_cold_white_mixer_core_defines.svh"

module cwm_queue #(
    parameter int DEPTH = cwm_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  cwm_pkg::t_job      i_job,
    input  wire logic          i_pop,
    output cwm_pkg::t_job      o_head,
    output logic               o_full,
    output logic               o_empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cwm_pkg::t_job    r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + IDX_W'(1);
            if (i_pop)  r_rd <= (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + IDX_W'(1);
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    `CWM_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `CWM_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `CWM_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CNT_W'(1), "fill count did not rise")

endmodule

`default_nettype wire

[hw/rtl/cwm_pipe_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a tag line.
// Depends on nothing; used by the back end.
`default_nettype none

module cwm_pipe_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 16,
    parameter int Q_W   = 20,
    parameter int TAG_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic      [Q_W-1:0]   o_quo,
    output logic      [TAG_W-1:0] o_tag
);

    logic [DEN_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_low [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [TAG_W-1:0] r_tag [Q_W];
    logic [Q_W-1:0]   r_vld;

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic [DEN_W-1:0] rem_in, den_in;
        logic [Q_W-1:0]   low_in, quo_in;
        logic [TAG_W-1:0] tag_in;
        logic             vld_in;
        logic [DEN_W:0]   trial;
        logic             ge;

        // Stage inputs: the operands at the head, the previous stage after it.
        always_comb begin
            if (s == 0) begin
                rem_in = DEN_W'(i_num >> Q_W);
                low_in = i_num[Q_W-1:0];
                quo_in = '0;
                den_in = i_den;
                tag_in = i_tag;
                vld_in = i_valid;
            end else begin
                rem_in = r_rem[(s == 0) ? 0 : s - 1];
                low_in = r_low[(s == 0) ? 0 : s - 1];
                quo_in = r_quo[(s == 0) ? 0 : s - 1];
                den_in = r_den[(s == 0) ? 0 : s - 1];
                tag_in = r_tag[(s == 0) ? 0 : s - 1];
                vld_in = r_vld[(s == 0) ? 0 : s - 1];
            end
            trial = {rem_in, low_in[Q_W-1]};
            ge    = trial >= {1'b0, den_in};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
                r_low[s] <= low_in << 1;
                r_quo[s] <= Q_W'({quo_in, ge});
                r_den[s] <= den_in;
                r_tag[s] <= tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)  r_vld[s] <= 1'b0;
            else if (i_en) r_vld[s] <= vld_in;
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_tag   = r_tag[Q_W-1];

endmodule

`default_nettype wire

[hw/rtl/cwm_back.sv]
// Back end: mired conversion, weight interpolation and level scaling.
// Depends on cwm_pkg and cwm_pipe_div.
`default_nettype none

module cwm_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  cwm_pkg::t_job        i_head,
    output logic                 o_pop,
    input  cwm_pkg::t_endpoints  i_ep,
    output logic                 o_out_valid,
    output cwm_pkg::t_out_item   o_out_item,
    input  wire logic            i_out_ready
);

    localparam int JOB_W = $bits(cwm_pkg::t_job);
    localparam int MIX_W = $bits(cwm_pkg::t_mix_tag);
    localparam int LVL_W = $bits(cwm_pkg::t_lvl_tag);
    localparam int MK_NUM_W = cwm_pkg::MIRED_W + 1;
    localparam int T_NUM_W  = 36;
    localparam int L_NUM_W  = 31;
    localparam int L_DEN_W  = 23;
    localparam int T_Q_W    = 15;

    logic adv;

    // The whole pipe moves whenever the output register can take a word.
    assign adv   = !o_out_valid || i_out_ready;
    assign o_pop = adv && !i_empty;

    // Target mired.
    logic                        d1_valid;
    logic [cwm_pkg::MIRED_W-1:0] d1_mk;
    logic [JOB_W-1:0]            d1_tag;

    cwm_pipe_div #(
        .NUM_W(MK_NUM_W), .DEN_W(cwm_pkg::KELVIN_W), .Q_W(cwm_pkg::MIRED_W), .TAG_W(JOB_W)
    ) u_div_mired (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(o_pop),
        .i_num(MK_NUM_W'(cwm_pkg::MIRED_SCALE)), .i_den(i_head.k), .i_tag(i_head),
        .o_valid(d1_valid), .o_quo(d1_mk), .o_tag(d1_tag)
    );

    // Pick the segment and form the interpolation dividend.
    logic                        r_s1_valid;
    cwm_pkg::t_mix_tag           r_s1_tag;
    logic [T_NUM_W-1:0]          r_s1_num;
    logic [cwm_pkg::MIRED_W-1:0] r_s1_den;
    logic                        s1_hi;
    logic [cwm_pkg::MIRED_W-1:0] s1_diff, s1_den;

    always_comb begin
        s1_hi   = d1_mk >= i_ep.neutral_m;
        s1_diff = s1_hi ? d1_mk - i_ep.neutral_m : d1_mk - i_ep.cold_m;
        s1_den  = s1_hi ? i_ep.warm_m - i_ep.neutral_m : i_ep.neutral_m - i_ep.cold_m;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_tag <= '{job: cwm_pkg::t_job'(d1_tag), hi: s1_hi,
                          sat_w: d1_mk >= i_ep.warm_m, sat_c: d1_mk <= i_ep.cold_m};
            r_s1_num <= T_NUM_W'(s1_diff) * T_NUM_W'(cwm_pkg::Q15_SPAN)
                        + T_NUM_W'(s1_den >> 1);
            r_s1_den <= s1_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_valid <= 1'b0;
        else if (adv) r_s1_valid <= d1_valid;
    end

    // Interpolated weight fraction.
    logic             d2_valid;
    logic [T_Q_W-1:0] d2_q;
    logic [MIX_W-1:0] d2_tag_bits;

    cwm_pipe_div #(
        .NUM_W(T_NUM_W), .DEN_W(cwm_pkg::MIRED_W), .Q_W(T_Q_W), .TAG_W(MIX_W)
    ) u_div_weight (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r_s1_valid),
        .i_num(r_s1_num), .i_den(r_s1_den), .i_tag(r_s1_tag),
        .o_valid(d2_valid), .o_quo(d2_q), .o_tag(d2_tag_bits)
    );

    // Warm weight, cold weight, the larger and the smaller of the two.
    cwm_pkg::t_mix_tag            d2_tag;
    logic [cwm_pkg::WEIGHT_W:0]   t_wide;
    logic [cwm_pkg::WEIGHT_W-1:0] t_w, c_w;
    logic                         r_s2_valid;
    cwm_pkg::t_lvl_tag            r_s2_tag;
    logic [cwm_pkg::WEIGHT_W-1:0] r_s2_max, r_s2_min;

    always_comb begin
        d2_tag = cwm_pkg::t_mix_tag'(d2_tag_bits);
        if (d2_tag.sat_w)      t_wide = 17'(cwm_pkg::WEIGHT_FULL);
        else if (d2_tag.sat_c) t_wide = '0;
        else if (d2_tag.hi)    t_wide = 17'(cwm_pkg::Q15_HALF) + 17'(d2_q);
        else                   t_wide = 17'(d2_q);
        t_w = (t_wide > 17'(cwm_pkg::WEIGHT_FULL)) ? cwm_pkg::WEIGHT_FULL
                                                  : cwm_pkg::WEIGHT_W'(t_wide);
        c_w = cwm_pkg::WEIGHT_FULL - t_w;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_tag <= '{job: d2_tag.job, warm_strong: t_w > c_w};
            r_s2_max <= (t_w > c_w) ? t_w : c_w;
            r_s2_min <= (t_w > c_w) ? c_w : t_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_valid <= 1'b0;
        else if (adv) r_s2_valid <= d2_valid;
    end

    // Dividend and divisor of the weaker channel's level.
    logic               r_s3_valid;
    cwm_pkg::t_lvl_tag  r_s3_tag;
    logic [L_NUM_W-1:0] r_s3_num;
    logic [L_DEN_W-1:0] r_s3_den;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_tag <= r_s2_tag;
            r_s3_num <= L_NUM_W'(r_s2_tag.job.b255) * L_NUM_W'(r_s2_min)
                        + L_NUM_W'(r_s2_max >> 1);
            r_s3_den <= L_DEN_W'(r_s2_max) * L_DEN_W'(cwm_pkg::BRI_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_valid <= 1'b0;
        else if (adv) r_s3_valid <= r_s2_valid;
    end

    // Weaker channel level.
    logic                       d3_valid;
    logic [cwm_pkg::LEVEL_W-1:0] d3_q;
    logic [LVL_W-1:0]           d3_tag_bits;

    cwm_pipe_div #(
        .NUM_W(L_NUM_W), .DEN_W(L_DEN_W), .Q_W(cwm_pkg::LEVEL_W), .TAG_W(LVL_W)
    ) u_div_level (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r_s3_valid),
        .i_num(r_s3_num), .i_den(r_s3_den), .i_tag(r_s3_tag),
        .o_valid(d3_valid), .o_quo(d3_q), .o_tag(d3_tag_bits)
    );

    // Final selection into the output register.
    cwm_pkg::t_lvl_tag  d3_tag;
    cwm_pkg::t_out_item res;

    always_comb begin
        d3_tag = cwm_pkg::t_lvl_tag'(d3_tag_bits);
        res    = '0;
        unique case (d3_tag.job.kind)
            cwm_pkg::KIND_OFF:       res = '0;
            cwm_pkg::KIND_WARM_ONLY: res.warm_level = d3_tag.job.full;
            cwm_pkg::KIND_COLD_ONLY: res.cold_level = d3_tag.job.full;
            cwm_pkg::KIND_BOTH_FULL: res = '{warm_level: d3_tag.job.full,
                                             cold_level: d3_tag.job.full};
            cwm_pkg::KIND_MIX: begin
                if (d3_tag.warm_strong) res = '{warm_level: d3_tag.job.lead, cold_level: d3_q};
                else                    res = '{warm_level: d3_q, cold_level: d3_tag.job.lead};
            end
            default: res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) o_out_item <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_out_valid <= 1'b0;
        else if (adv) o_out_valid <= d3_valid;
    end

endmodule

`default_nettype wire

[hw/rtl/cct_warm_cold_white_mixer_core.sv]
// Tunable-white mixer: one light setting per cycle in, one level word per cycle out,
// while no serial conversion runs and the output is taken. The queued word enters a
// 20-stage mired divider, then a 15-stage weight divider, an 8-stage level divider
// and four register stages; an output stall holds the whole pipeline.
// Reset loads the default endpoints and their mireds; after each register write the
// mireds are rebuilt by a serial divider, during which no word is taken.
`default_nettype none

module cct_warm_cold_white_mixer_core #(
    parameter int QUEUE_DEPTH = cwm_pkg::QUEUE_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  cwm_pkg::t_in_item        i_in_item,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output cwm_pkg::t_out_item       o_out_item,
    input  wire logic                i_out_ready,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    cwm_pkg::t_endpoints ep;
    cwm_pkg::t_job       push_job, head_job;
    logic                busy, push, pop, full, empty;

    // Registers and endpoint mireds.
    cwm_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .o_busy(busy), .o_ep(ep)
    );

    // Classification.
    cwm_front u_front (
        .i_in_valid(i_in_valid), .i_in_item(i_in_item), .o_in_ready(o_in_ready),
        .i_ep(ep), .i_busy(busy), .i_full(full), .o_push(push), .o_job(push_job)
    );

    // Decoupling queue.
    cwm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(push_job),
        .i_pop(pop), .o_head(head_job), .o_full(full), .o_empty(empty)
    );

    // Arithmetic pipeline and output register.
    cwm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_head(head_job),
        .o_pop(pop), .i_ep(ep), .o_out_valid(o_out_valid), .o_out_item(o_out_item),
        .i_out_ready(i_out_ready)
    );

endmodule

`default_nettype wire
